// ===== src/col_pkg.sv =====
// Shared types and constants for the C operator lexer.
package col_pkg;

  // Most results one source byte can cause.
  localparam int MAX_RES = 3;
  // Depth of the bundle queue between scanner and output serializer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    TOK_NE          = 6'd0,
    TOK_NOT         = 6'd1,
    TOK_MOD_ASSIGN  = 6'd2,
    TOK_MOD         = 6'd3,
    TOK_ANDAND      = 6'd4,
    TOK_AND_ASSIGN  = 6'd5,
    TOK_AMP         = 6'd6,
    TOK_LPAREN      = 6'd7,
    TOK_RPAREN      = 6'd8,
    TOK_MUL_ASSIGN  = 6'd9,
    TOK_STAR        = 6'd10,
    TOK_INC         = 6'd11,
    TOK_ADD_ASSIGN  = 6'd12,
    TOK_PLUS        = 6'd13,
    TOK_COMMA       = 6'd14,
    TOK_DEC         = 6'd15,
    TOK_ARROW       = 6'd16,
    TOK_SUB_ASSIGN  = 6'd17,
    TOK_MINUS       = 6'd18,
    TOK_DOT         = 6'd19,
    TOK_DIV_ASSIGN  = 6'd20,
    TOK_SLASH       = 6'd21,
    TOK_SCOPE       = 6'd22,
    TOK_COLON       = 6'd23,
    TOK_SHL_ASSIGN  = 6'd24,
    TOK_SHL         = 6'd25,
    TOK_SPACESHIP   = 6'd26,
    TOK_LE          = 6'd27,
    TOK_LT          = 6'd28,
    TOK_EQ          = 6'd29,
    TOK_ASSIGN      = 6'd30,
    TOK_SHR_ASSIGN  = 6'd31,
    TOK_SHR         = 6'd32,
    TOK_GE          = 6'd33,
    TOK_GT          = 6'd34,
    TOK_QUEST       = 6'd35,
    TOK_LBRACK      = 6'd36,
    TOK_RBRACK      = 6'd37,
    TOK_XOR_ASSIGN  = 6'd38,
    TOK_CARET       = 6'd39,
    TOK_LBRACE      = 6'd40,
    TOK_OROR        = 6'd41,
    TOK_OR_ASSIGN   = 6'd42,
    TOK_PIPE        = 6'd43,
    TOK_RBRACE      = 6'd44,
    TOK_TILDE       = 6'd45,
    TOK_SEMI        = 6'd46,
    TOK_CHAR        = 6'd47,
    TOK_STRING      = 6'd48,
    TOK_IDENT       = 6'd49
  } token_t;

  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_CHAR   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    token_t      code;
    kind_t       kind;
    logic [7:0]  val;
  } item_t;

  // All results of one source byte; count is 1..MAX_RES when queued.
  typedef struct packed {
    logic [1:0]                count;
    item_t [MAX_RES-1:0]       items;
  } bundle_t;

endpackage

// ===== src/c_operator_lexer.sv =====
// Top level of the C operator lexer: scanner, bundle queue and output serializer.
//
// Source bytes enter on the s_ side, one request per cycle, and tokens leave
// on the m_ side. The scanner takes a byte every cycle while the bundle queue
// has room; each byte yields zero to three result items (a pending punctuator
// plus the header and first character of a new identifier is one longest
// case), which are queued together as one bundle. The output side sends one
// item per cycle while m_tready is high; a byte's results wait in the bundle
// queue until earlier bundles have drained. The four-entry bundle queue lets
// input keep flowing at one byte per cycle while output is stalled
// or draining a burst; s_tready drops only when all four entries hold bundles.
// m_tlast marks the final item caused by one input byte. Text tokens (char
// constant, string, identifier) come out as a header item, one item per
// character and an end item; every word is reported as an identifier.
// The end_of_input flag flushes a held punctuator or closes open text.
module c_operator_lexer import col_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] token_code, [13:6] char_value, [15:14] zero
  output logic [1:0]  m_tuser,   // [1:0] item_kind
  output logic        m_tlast
);

  logic    push;
  bundle_t push_data;
  logic    full;
  logic    head_valid;
  bundle_t head;
  logic    pop;

  // Accept a byte whenever the queue can take a bundle.
  assign s_tready = !full;

  // Classify the byte and build its bundle.
  col_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .ch           (s_tdata),
    .end_of_input (s_tuser),
    .push         (push),
    .bundle       (push_data)
  );

  // Hold bundles until the output side drains them.
  col_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Advance through the head bundle one item per output request.
  col_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ===== src/col_front.sv =====
// Scanner front end: classifies each source byte and forms its result bundle.
module col_front import col_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  logic [7:0] ch,
  input  logic      end_of_input,
  output logic      push,
  output bundle_t   bundle
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_PUNCT,
    M_WORD,
    M_TEXT,
    M_ESC
  } mode_t;

  typedef enum logic [1:0] {
    EXT_NONE,
    EXT_DONE,
    EXT_HOLD
  } ext_t;

  typedef enum logic [2:0] {
    ST_SKIP,
    ST_SINGLE,
    ST_HOLD,
    ST_QCHAR,
    ST_QSTRING,
    ST_WORD
  } start_t;

  typedef struct packed {
    ext_t   kind;
    token_t code;
  } ext_res_t;

  typedef struct packed {
    start_t cls;
    token_t code;
  } start_res_t;

  localparam logic [1:0] TK_NONE   = 2'd0;
  localparam logic [1:0] TK_CHAR   = 2'd1;
  localparam logic [1:0] TK_STRING = 2'd2;
  localparam logic [1:0] TK_IDENT  = 2'd3;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_FF     = 8'hFF;

  function automatic ext_res_t extend(input token_t p, input logic [7:0] c);
    ext_res_t r;
    r = '{kind: EXT_NONE, code: TOK_NE};
    case (p)
      TOK_NOT:   if (c == 8'h3D) r = '{EXT_DONE, TOK_NE};
      TOK_MOD:   if (c == 8'h3D) r = '{EXT_DONE, TOK_MOD_ASSIGN};
      TOK_AMP: begin
        if (c == 8'h26) r = '{EXT_DONE, TOK_ANDAND};
        else if (c == 8'h3D) r = '{EXT_DONE, TOK_AND_ASSIGN};
      end
      TOK_STAR:  if (c == 8'h3D) r = '{EXT_DONE, TOK_MUL_ASSIGN};
      TOK_PLUS: begin
        if (c == 8'h2B) r = '{EXT_DONE, TOK_INC};
        else if (c == 8'h3D) r = '{EXT_DONE, TOK_ADD_ASSIGN};
      end
      TOK_MINUS: begin
        if (c == 8'h2D) r = '{EXT_DONE, TOK_DEC};
        else if (c == 8'h3E) r = '{EXT_DONE, TOK_ARROW};
        else if (c == 8'h3D) r = '{EXT_DONE, TOK_SUB_ASSIGN};
      end
      TOK_SLASH: if (c == 8'h3D) r = '{EXT_DONE, TOK_DIV_ASSIGN};
      TOK_COLON: if (c == 8'h3A) r = '{EXT_DONE, TOK_SCOPE};
      TOK_LT: begin
        if (c == 8'h3C) r = '{EXT_HOLD, TOK_SHL};
        else if (c == 8'h3D) r = '{EXT_HOLD, TOK_LE};
      end
      TOK_SHL:   if (c == 8'h3D) r = '{EXT_DONE, TOK_SHL_ASSIGN};
      TOK_LE:    if (c == 8'h3E) r = '{EXT_DONE, TOK_SPACESHIP};
      TOK_ASSIGN: if (c == 8'h3D) r = '{EXT_DONE, TOK_EQ};
      TOK_GT: begin
        if (c == 8'h3E) r = '{EXT_HOLD, TOK_SHR};
        else if (c == 8'h3D) r = '{EXT_DONE, TOK_GE};
      end
      TOK_SHR:   if (c == 8'h3D) r = '{EXT_DONE, TOK_SHR_ASSIGN};
      TOK_CARET: if (c == 8'h3D) r = '{EXT_DONE, TOK_XOR_ASSIGN};
      TOK_PIPE: begin
        if (c == 8'h7C) r = '{EXT_DONE, TOK_OROR};
        else if (c == 8'h3D) r = '{EXT_DONE, TOK_OR_ASSIGN};
      end
      default: r = '{kind: EXT_NONE, code: TOK_NE};
    endcase
    return r;
  endfunction

  function automatic start_res_t classify(input logic [7:0] c);
    start_res_t r;
    r = '{cls: ST_WORD, code: TOK_IDENT};
    case (c)
      8'h28: r = '{ST_SINGLE, TOK_LPAREN};
      8'h29: r = '{ST_SINGLE, TOK_RPAREN};
      8'h2C: r = '{ST_SINGLE, TOK_COMMA};
      8'h2E: r = '{ST_SINGLE, TOK_DOT};
      8'h3F: r = '{ST_SINGLE, TOK_QUEST};
      8'h5B: r = '{ST_SINGLE, TOK_LBRACK};
      8'h5D: r = '{ST_SINGLE, TOK_RBRACK};
      8'h7B: r = '{ST_SINGLE, TOK_LBRACE};
      8'h7D: r = '{ST_SINGLE, TOK_RBRACE};
      8'h7E: r = '{ST_SINGLE, TOK_TILDE};
      8'h3B: r = '{ST_SINGLE, TOK_SEMI};
      8'h21: r = '{ST_HOLD, TOK_NOT};
      8'h25: r = '{ST_HOLD, TOK_MOD};
      8'h26: r = '{ST_HOLD, TOK_AMP};
      8'h2A: r = '{ST_HOLD, TOK_STAR};
      8'h2B: r = '{ST_HOLD, TOK_PLUS};
      8'h2D: r = '{ST_HOLD, TOK_MINUS};
      8'h2F: r = '{ST_HOLD, TOK_SLASH};
      8'h3A: r = '{ST_HOLD, TOK_COLON};
      8'h3C: r = '{ST_HOLD, TOK_LT};
      8'h3D: r = '{ST_HOLD, TOK_ASSIGN};
      8'h3E: r = '{ST_HOLD, TOK_GT};
      8'h5E: r = '{ST_HOLD, TOK_CARET};
      8'h7C: r = '{ST_HOLD, TOK_PIPE};
      8'h09, 8'h0A, 8'h0D, 8'h20, CH_FF: r = '{ST_SKIP, TOK_IDENT};
      CH_SQUOTE: r = '{ST_QCHAR, TOK_CHAR};
      CH_DQUOTE: r = '{ST_QSTRING, TOK_STRING};
      default: r = '{cls: ST_WORD, code: TOK_IDENT};
    endcase
    return r;
  endfunction

  function automatic logic word_byte(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDER);
  endfunction

  mode_t      mode, mode_next;
  token_t     pending, pending_next;
  logic [1:0] text_kind, text_kind_next;

  token_t     tcode;
  ext_res_t   ext;
  start_res_t st;
  logic       do_start;
  logic [1:0] n;
  logic [7:0] esc_val;
  logic [7:0] close_ch;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    case (text_kind)
      TK_CHAR:   tcode = TOK_CHAR;
      TK_STRING: tcode = TOK_STRING;
      TK_IDENT:  tcode = TOK_IDENT;
      default:   tcode = TOK_SEMI;
    endcase
  end

  always_comb begin
    ext      = extend(pending, ch);
    st       = classify(ch);
    close_ch = (text_kind == TK_CHAR) ? CH_SQUOTE : CH_DQUOTE;
    case (ch)
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      default: esc_val = ch;
    endcase

    n              = 2'd0;
    bundle         = '0;
    mode_next      = mode;
    pending_next   = pending;
    text_kind_next = text_kind;
    do_start       = 1'b0;

    if (end_of_input) begin
      if (mode == M_PUNCT) begin
        bundle.items[n] = '{code: pending, kind: KIND_PLAIN, val: 8'h00};
        n = n + 2'd1;
      end else if (mode != M_IDLE) begin
        bundle.items[n] = '{code: tcode, kind: KIND_END, val: 8'h00};
        n = n + 2'd1;
      end
      mode_next      = M_IDLE;
      pending_next   = TOK_NE;
      text_kind_next = TK_NONE;
    end else begin
      case (mode)
        M_PUNCT: begin
          if (ext.kind == EXT_HOLD) begin
            pending_next = ext.code;
          end else if (ext.kind == EXT_DONE) begin
            bundle.items[n] = '{code: ext.code, kind: KIND_PLAIN, val: 8'h00};
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            bundle.items[n] = '{code: pending, kind: KIND_PLAIN, val: 8'h00};
            n = n + 2'd1;
            mode_next = M_IDLE;
            do_start  = 1'b1;
          end
        end
        M_WORD: begin
          if (word_byte(ch)) begin
            bundle.items[n] = '{code: TOK_IDENT, kind: KIND_CHAR, val: ch};
            n = n + 2'd1;
          end else begin
            bundle.items[n] = '{code: TOK_IDENT, kind: KIND_END, val: 8'h00};
            n = n + 2'd1;
            mode_next = M_IDLE;
            do_start  = 1'b1;
          end
        end
        M_TEXT: begin
          if (ch == CH_BSLASH) begin
            mode_next = M_ESC;
          end else if (ch == close_ch) begin
            bundle.items[n] = '{code: tcode, kind: KIND_END, val: 8'h00};
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else begin
            bundle.items[n] = '{code: tcode, kind: KIND_CHAR, val: ch};
            n = n + 2'd1;
          end
        end
        M_ESC: begin
          bundle.items[n] = '{code: tcode, kind: KIND_CHAR, val: esc_val};
          n = n + 2'd1;
          mode_next = M_TEXT;
        end
        default: begin
          mode_next = M_IDLE;
          do_start  = 1'b1;
        end
      endcase

      if (do_start) begin
        case (st.cls)
          ST_SKIP: begin
          end
          ST_SINGLE: begin
            bundle.items[n] = '{code: st.code, kind: KIND_PLAIN, val: 8'h00};
            n = n + 2'd1;
          end
          ST_HOLD: begin
            pending_next = st.code;
            mode_next    = M_PUNCT;
          end
          ST_QCHAR: begin
            text_kind_next = TK_CHAR;
            mode_next      = M_TEXT;
            bundle.items[n] = '{code: TOK_CHAR, kind: KIND_HEADER, val: 8'h00};
            n = n + 2'd1;
          end
          ST_QSTRING: begin
            text_kind_next = TK_STRING;
            mode_next      = M_TEXT;
            bundle.items[n] = '{code: TOK_STRING, kind: KIND_HEADER, val: 8'h00};
            n = n + 2'd1;
          end
          default: begin
            text_kind_next = TK_IDENT;
            mode_next      = M_WORD;
            bundle.items[n] = '{code: TOK_IDENT, kind: KIND_HEADER, val: 8'h00};
            n = n + 2'd1;
            bundle.items[n] = '{code: TOK_IDENT, kind: KIND_CHAR, val: ch};
            n = n + 2'd1;
          end
        endcase
      end
    end
    bundle.count = n;
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      pending   <= TOK_NE;
      text_kind <= TK_NONE;
    end else if (accept) begin
      mode      <= mode_next;
      pending   <= pending_next;
      text_kind <= text_kind_next;
    end
  end

  a_pend_nonzero: assert property (@(posedge clk) disable iff (rst)
    mode == M_PUNCT |-> pending != TOK_NE)
    else $error("punctuator pending with no prefix code");

  a_text_kind_set: assert property (@(posedge clk) disable iff (rst)
    (mode == M_TEXT || mode == M_ESC) |-> (text_kind == TK_CHAR || text_kind == TK_STRING))
    else $error("quoted text open without a quote kind");

  a_idle_after_eoi: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> mode == M_IDLE && text_kind == TK_NONE)
    else $error("scanner not idle after end of input");

endmodule

// ===== src/col_queue.sv =====
// Short queue of result bundles between the scanner and the output side.
module col_queue import col_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  output logic    head_valid,
  output bundle_t head,
  input  logic    pop
);

  bundle_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("bundle pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("bundle popped from an empty queue");

  a_nonempty_bundle: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.count != 2'd0)
    else $error("empty bundle at queue head");

endmodule

// ===== src/col_back.sv =====
// Output serializer: sends the items of each queued bundle one per cycle while m_tready is high.
module col_back import col_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  bundle_t     head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic [1:0] idx;
  item_t      cur;
  logic       final_item;
  logic       send;

  assign cur        = head.items[idx];
  assign final_item = (idx == head.count - 2'd1);
  assign send       = m_tvalid && m_tready;

  assign m_tvalid = head_valid;
  assign m_tdata  = {2'b00, cur.val, cur.code};
  assign m_tuser  = cur.kind;
  assign m_tlast  = final_item;
  assign pop      = send && final_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (send) begin
      idx <= final_item ? 2'd0 : idx + 2'd1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.count)
    else $error("item index past end of bundle");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(idx))
    else $error("item index moved while output stalled");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == 2'd0)
    else $error("item index not rewound after bundle");

endmodule
